[design/rts_pkg.sv]
`default_nettype none

package rts_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int SMP_W       = 12;
    localparam int PRESS_W     = 16;
    localparam int PROD_W      = 2 * SMP_W;
    localparam int DVD_W       = SMP_W + 20;
    localparam int CNT_W       = $clog2(DVD_W);

    localparam logic [SMP_W-1:0]   SAMPLE_MASK = SMP_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [PRESS_W-1:0] PRESS_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_PEN_IRQ    = 2'd0,
        CMD_PEN_STATUS = 2'd1,
        CMD_CONVERSION = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        REQ_WAIT    = 3'd0,
        REQ_STATUS  = 3'd1,
        REQ_CONV_XP = 3'd2,
        REQ_CONV_YP = 3'd3,
        REQ_CONV_YN = 3'd4
    } request_t;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_DEBOUNCE,
        PH_CONV_Y,
        PH_CONV_X,
        PH_CONV_XP,
        PH_CONV_YN
    } phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_MUL,
        CTL_DIV,
        CTL_DONE
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]       command;
        logic             pen_down;
        logic [SMP_W-1:0] sample;
        logic             sample_error;
    } cmd_t;

    typedef struct packed {
        logic [2:0]         next_request;
        logic               report_valid;
        logic               touch;
        logic [SMP_W-1:0]   x_pos;
        logic [SMP_W-1:0]   y_pos;
        logic [PRESS_W-1:0] pressure;
    } rpt_t;

    function automatic logic [2:0] request_of(input phase_t ph);
        logic [2:0] req;
        unique case (ph)
            PH_DEBOUNCE: req = REQ_STATUS;
            PH_CONV_Y:   req = REQ_CONV_XP;
            PH_CONV_X:   req = REQ_CONV_YP;
            PH_CONV_XP:  req = REQ_CONV_XP;
            PH_CONV_YN:  req = REQ_CONV_YN;
            default:     req = REQ_WAIT;
        endcase
        return req;
    endfunction

endpackage

`default_nettype wire

[design/resistive_touch_sequencer.sv]
`default_nettype none

// Channel   Signals                    Direction  Contents
// cmd       cmd_valid, cmd_stall, cmd  in         pen interrupt, status or conversion
// rpt       rpt_valid, rpt_stall, rpt  out        next request and optional report
//
// A request that needs no pressure computation is answered in the cycle after it is accepted.
// A final conversion with a usable sample passes through the accepting cycle, a
// multiply step, the restoring divider stage and a finishing step, in that order.
// Reset returns the sequencer to waiting for the pen interrupt.
// A new request is taken only while the block is idle and the result register
// is empty or being read in the same cycle.
module resistive_touch_sequencer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_stall,
    input  wire rts_pkg::cmd_t cmd,
    output logic               rpt_valid,
    input  wire logic          rpt_stall,
    output rts_pkg::rpt_t      rpt
);
    import rts_pkg::*;

    ctl_state_t           state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic                 pen_prev_reg, pen_prev_next;
    logic [SMP_W-1:0]     x_held_reg, x_held_next;
    logic [SMP_W-1:0]     y_held_reg, y_held_next;
    logic [SMP_W-1:0]     xp_held_reg, xp_held_next;
    logic [PRESS_W-1:0]   press_held_reg, press_held_next;
    logic                 rpt_valid_reg, rpt_valid_next;
    rpt_t                 rpt_reg, rpt_next;

    logic [SMP_W-1:0]     diff_reg, diff_next;
    logic [PROD_W-1:0]    divisor_reg, divisor_next;
    logic [DVD_W-1:0]     quot_reg, quot_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    logic                 accept;
    logic [SMP_W-1:0]     smp;
    logic                 rep;
    logic                 emit;
    logic [PROD_W:0]      rem_shift;
    logic [PROD_W:0]      rem_sub;
    logic [PRESS_W-1:0]   press_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CTL_IDLE;
            phase_reg      <= PH_WAIT;
            pen_prev_reg   <= 1'b1;
            x_held_reg     <= '0;
            y_held_reg     <= '0;
            xp_held_reg    <= '0;
            press_held_reg <= '0;
            rpt_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pen_prev_reg   <= pen_prev_next;
            x_held_reg     <= x_held_next;
            y_held_reg     <= y_held_next;
            xp_held_reg    <= xp_held_next;
            press_held_reg <= press_held_next;
            rpt_valid_reg  <= rpt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rpt_reg     <= rpt_next;
        diff_reg    <= diff_next;
        divisor_reg <= divisor_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        count_reg   <= count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pen_prev_next   = pen_prev_reg;
        x_held_next     = x_held_reg;
        y_held_next     = y_held_reg;
        xp_held_next    = xp_held_reg;
        press_held_next = press_held_reg;
        rpt_valid_next  = rpt_valid_reg && rpt_stall;
        rpt_next        = rpt_reg;
        diff_next       = diff_reg;
        divisor_next    = divisor_reg;
        quot_next       = quot_reg;
        rem_next        = rem_reg;
        count_next      = count_reg;

        cmd_stall = !((state_reg == CTL_IDLE) && (!rpt_valid_reg || !rpt_stall));
        accept    = cmd_valid && !cmd_stall;
        smp       = cmd.sample & SAMPLE_MASK;
        rep       = 1'b0;
        emit      = 1'b0;
        rem_shift = {rem_reg, quot_reg[DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        press_sat = (|quot_reg[DVD_W-1:PRESS_W]) ? PRESS_MAX : quot_reg[PRESS_W-1:0];

        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    emit = 1'b1;
                    unique case (cmd.command)
                        CMD_PEN_IRQ:
                        begin
                            if (phase_reg == PH_WAIT)
                            begin
                                phase_next    = PH_DEBOUNCE;
                                pen_prev_next = 1'b1;
                            end
                        end
                        CMD_PEN_STATUS:
                        begin
                            if (phase_reg == PH_DEBOUNCE)
                            begin
                                if (cmd.pen_down == pen_prev_reg)
                                begin
                                    if (cmd.pen_down)
                                    begin
                                        phase_next = PH_CONV_Y;
                                    end
                                    else
                                    begin
                                        rep             = press_held_reg != '0;
                                        phase_next      = PH_WAIT;
                                        press_held_next = '0;
                                    end
                                end
                                pen_prev_next = cmd.pen_down;
                            end
                        end
                        CMD_CONVERSION:
                        begin
                            priority if (cmd.sample_error && (phase_reg == PH_CONV_Y
                                    || phase_reg == PH_CONV_X || phase_reg == PH_CONV_XP
                                    || phase_reg == PH_CONV_YN))
                            begin
                                rep             = press_held_reg != '0;
                                phase_next      = PH_WAIT;
                                press_held_next = '0;
                            end
                            else if (phase_reg == PH_CONV_Y)
                            begin
                                y_held_next = smp;
                                phase_next  = PH_CONV_X;
                            end
                            else if (phase_reg == PH_CONV_X)
                            begin
                                x_held_next = smp;
                                phase_next  = PH_CONV_XP;
                            end
                            else if (phase_reg == PH_CONV_XP)
                            begin
                                xp_held_next = smp;
                                phase_next   = PH_CONV_YN;
                            end
                            else if (phase_reg == PH_CONV_YN)
                            begin
                                phase_next = PH_DEBOUNCE;
                                if (xp_held_reg != '0 && smp > xp_held_reg
                                        && x_held_reg != '0)
                                begin
                                    diff_next  = smp - xp_held_reg;
                                    state_next = CTL_MUL;
                                    emit       = 1'b0;
                                end
                            end
                            else
                            begin
                                phase_next = phase_reg;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                    if (emit)
                    begin
                        rpt_valid_next        = 1'b1;
                        rpt_next              = '0;
                        rpt_next.next_request = request_of(phase_next);
                        rpt_next.report_valid = rep;
                    end
                end
            end
            CTL_MUL:
            begin
                divisor_next = x_held_reg * diff_reg;
                quot_next    = {xp_held_reg, (DVD_W - SMP_W)'(0)};
                rem_next     = '0;
                count_next   = '0;
                state_next   = CTL_DIV;
            end
            CTL_DIV:
            begin
                if (!rem_sub[PROD_W])
                begin
                    rem_next  = rem_sub[PROD_W-1:0];
                    quot_next = {quot_reg[DVD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[PROD_W-1:0];
                    quot_next = {quot_reg[DVD_W-2:0], 1'b0};
                end
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(DVD_W - 1))
                begin
                    state_next = CTL_DONE;
                end
            end
            CTL_DONE:
            begin
                rpt_valid_next        = 1'b1;
                rpt_next              = '0;
                rpt_next.next_request = request_of(phase_reg);
                if (quot_reg != '0)
                begin
                    press_held_next       = press_sat;
                    rpt_next.report_valid = 1'b1;
                    rpt_next.touch        = 1'b1;
                    rpt_next.x_pos        = x_held_reg;
                    rpt_next.y_pos        = y_held_reg;
                    rpt_next.pressure     = press_sat;
                end
                state_next = CTL_IDLE;
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;

endmodule

`default_nettype wire

[verif/tb_resistive_touch_sequencer.sv]
`timescale 1ns / 1ps

module tb_resistive_touch_sequencer;

    import rts_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int         LONG_HOLD   = 400;

    class touch_scoreboard;
        phase_t           phase;
        logic             pen_prev;
        logic [SMP_W-1:0] x_held;
        logic [SMP_W-1:0] y_held;
        logic [SMP_W-1:0] xp_held;
        logic [15:0]      press_held;
        rpt_t             expected_reports[$];
        int               mismatches;
        int               checked;
        int               touches;
        int               releases;
        int               discarded;
        int               saturated;

        function new();
            phase      = PH_WAIT;
            pen_prev   = 1'b1;
            x_held     = '0;
            y_held     = '0;
            xp_held    = '0;
            press_held = '0;
            mismatches = 0;
            checked    = 0;
            touches    = 0;
            releases   = 0;
            discarded  = 0;
            saturated  = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void note_request(cmd_t c);
            rpt_t             want;
            logic [SMP_W-1:0] smp;
            logic [63:0]      quo;
            logic             rep;
            logic             tch;
            rep = 1'b0;
            tch = 1'b0;
            smp = c.sample & SAMPLE_MASK;
            case (c.command)
                CMD_PEN_IRQ:
                begin
                    if (phase == PH_WAIT)
                    begin
                        phase    = PH_DEBOUNCE;
                        pen_prev = 1'b1;
                    end
                end
                CMD_PEN_STATUS:
                begin
                    if (phase == PH_DEBOUNCE)
                    begin
                        if (c.pen_down == pen_prev)
                        begin
                            if (c.pen_down)
                                phase = PH_CONV_Y;
                            else
                            begin
                                rep        = (press_held != 0);
                                phase      = PH_WAIT;
                                press_held = '0;
                            end
                        end
                        pen_prev = c.pen_down;
                    end
                end
                CMD_CONVERSION:
                begin
                    if (phase >= PH_CONV_Y && phase <= PH_CONV_YN && c.sample_error)
                    begin
                        rep        = (press_held != 0);
                        phase      = PH_WAIT;
                        press_held = '0;
                    end
                    else if (phase == PH_CONV_Y)
                    begin
                        y_held = smp;
                        phase  = PH_CONV_X;
                    end
                    else if (phase == PH_CONV_X)
                    begin
                        x_held = smp;
                        phase  = PH_CONV_XP;
                    end
                    else if (phase == PH_CONV_XP)
                    begin
                        xp_held = smp;
                        phase   = PH_CONV_YN;
                    end
                    else if (phase == PH_CONV_YN)
                    begin
                        phase = PH_DEBOUNCE;
                        quo   = '0;
                        if (xp_held != 0 && smp > xp_held && x_held != 0)
                            quo = (64'(xp_held) << 20) / 64'(x_held) / 64'(smp - xp_held);
                        if (quo != 0)
                        begin
                            if (quo > 64'(PRESS_MAX))
                            begin
                                press_held = PRESS_MAX;
                                saturated++;
                            end
                            else
                                press_held = quo[15:0];
                            rep = 1'b1;
                            tch = 1'b1;
                        end
                        else
                            discarded++;
                    end
                end
                default:
                begin
                end
            endcase

            want = '0;
            case (phase)
                PH_DEBOUNCE: want.next_request = REQ_STATUS;
                PH_CONV_Y:   want.next_request = REQ_CONV_XP;
                PH_CONV_X:   want.next_request = REQ_CONV_YP;
                PH_CONV_XP:  want.next_request = REQ_CONV_XP;
                PH_CONV_YN:  want.next_request = REQ_CONV_YN;
                default:     want.next_request = REQ_WAIT;
            endcase
            if (rep)
            begin
                want.report_valid = 1'b1;
                if (tch)
                begin
                    want.touch    = 1'b1;
                    want.x_pos    = x_held;
                    want.y_pos    = y_held;
                    want.pressure = press_held;
                    touches++;
                end
                else
                    releases++;
            end
            expected_reports.push_back(want);
        endfunction

        function void check_report(rpt_t got);
            rpt_t want;
            logic bad;
            checked++;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected report %p", got);
                return;
            end
            want = expected_reports.pop_front();
            bad = (got.next_request !== want.next_request)
                || (got.report_valid !== want.report_valid)
                || (got.touch !== want.touch)
                || (got.x_pos !== want.x_pos)
                || (got.y_pos !== want.y_pos)
                || (got.pressure !== want.pressure);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: report %0d expected %p actual %p", checked, want, got);
            end
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            cmd_valid;
    logic            cmd_stall;
    cmd_t            cmd;
    logic            rpt_valid;
    logic            rpt_stall;
    rpt_t            rpt;

    touch_scoreboard board;
    bit              calm;
    bit              long_hold_done;
    int              items_sent;

    resistive_touch_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rpt_valid (rpt_valid),
        .rpt_stall (rpt_stall),
        .rpt       (rpt)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic cmd_t make_request(logic [1:0] code, logic pen, logic [SMP_W-1:0] smp,
                                          logic err);
        cmd_t c;
        c.command      = code;
        c.pen_down     = pen;
        c.sample       = smp;
        c.sample_error = err;
        return c;
    endfunction

    task automatic send_request(input cmd_t c);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        board.note_request(c);
        items_sent++;
    endtask

    task automatic send_status(input logic pen);
        send_request(make_request(CMD_PEN_STATUS, pen, 12'($urandom), 1'($urandom)));
    endtask

    task automatic send_conversion(input logic [SMP_W-1:0] v, input logic err);
        send_request(make_request(CMD_CONVERSION, 1'($urandom), v, err));
    endtask

    task automatic touch_measurement();
        logic [SMP_W-1:0] y;
        logic [SMP_W-1:0] x;
        logic [SMP_W-1:0] xp;
        logic [SMP_W-1:0] yn;
        int               r;
        y = 12'($urandom_range(0, 4095));
        x = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 4095));
        r = $urandom_range(0, 9);
        if (r == 0)
            xp = 12'd0;
        else if (r == 1)
            xp = 12'd4095;
        else
            xp = 12'($urandom_range(1, 4094));
        if ($urandom_range(0, 7) == 0 || xp == 12'd4095)
            yn = 12'($urandom_range(0, int'(xp)));
        else
            yn = 12'($urandom_range(int'(xp) + 1, 4095));
        send_status(1'b1);
        send_status(1'b1);
        send_conversion(y, $urandom_range(0, 15) == 0);
        send_conversion(x, $urandom_range(0, 15) == 0);
        send_conversion(xp, $urandom_range(0, 15) == 0);
        send_conversion(yn, $urandom_range(0, 15) == 0);
    endtask

    initial
    begin
        rpt_stall = 1'b0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin : receive_loop
            int gap;
            gap = calm ? 0 : $urandom_range(0, 16);
            if (!long_hold_done && board.checked >= 100)
            begin
                gap = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (gap > 0)
            begin
                rpt_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            rpt_stall <= 1'b0;
            @(posedge clk);
            while (!rpt_valid)
                @(posedge clk);
            board.check_report(rpt);
        end
    end

    initial
    begin
        #5_000_000;
        $display("resistive_touch_sequencer regression: fail");
        $finish;
    end

    initial
    begin : main
        int n;
        int k;
        board      = new();
        calm       = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_request(CMD_PEN_STATUS, 1'b1, 12'd4095, 1'b1));
        send_request(make_request(CMD_CONVERSION, 1'b0, 12'd4095, 1'b1));
        send_request(make_request(CMD_UNKNOWN, 1'b1, 12'd4095, 1'b1));
        send_request(make_request(CMD_PEN_IRQ, 1'b0, 12'd0, 1'b0));
        send_status(1'b0);
        send_status(1'b1);
        send_status(1'b1);
        send_request(make_request(CMD_PEN_IRQ, 1'b1, 12'd4095, 1'b1));
        send_conversion(12'd4095, 1'b0);
        send_conversion(12'd1, 1'b0);
        send_conversion(12'd4094, 1'b0);
        send_conversion(12'd4095, 1'b0);
        send_status(1'b1);
        send_status(1'b1);
        send_conversion(12'd0, 1'b0);
        send_conversion(12'd4095, 1'b0);
        send_conversion(12'd1, 1'b0);
        send_conversion(12'd4095, 1'b0);
        send_status(1'b1);
        send_status(1'b1);
        send_conversion(12'd0, 1'b1);
        send_request(make_request(CMD_PEN_IRQ, 1'b0, 12'd0, 1'b0));
        send_status(1'b0);
        send_status(1'b0);

        while (items_sent < 525)
        begin
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0)
            begin
                send_request(make_request(CMD_PEN_IRQ, 1'($urandom), 12'($urandom),
                                          1'($urandom)));
                k = $urandom_range(0, 2);
                repeat (k) send_status(1'($urandom));
                k = $urandom_range(1, 4);
                repeat (k) touch_measurement();
                send_status(1'b0);
                send_status(1'b0);
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k)
                    send_request(make_request(2'($urandom_range(0, 3)), 1'($urandom),
                                              12'($urandom), 1'($urandom)));
            end
        end
        calm = 1'b0;
        cmd_valid <= 1'b0;

        n = 0;
        while (board.pending() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (60) @(posedge clk);

        if (board.pending() != 0)
            $display("ERROR: %0d reports never arrived", board.pending());
        $display("Covered %0d requests and %0d reports: %0d touches, %0d releases,",
                 items_sent, board.checked, board.touches, board.releases);
        $display("%0d discarded samples, %0d saturated pressures, %0d mismatches.",
                 board.discarded, board.saturated, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("resistive_touch_sequencer regression: pass");
        else
            $display("resistive_touch_sequencer regression: fail");
        $finish;
    end

endmodule
